// ===== sv/gpm_pkg.sv =====
// Package for the GF(p) polynomial multiplier: shared widths.
// No dependencies.
`default_nettype none
package gpm_pkg;
  localparam int unsigned IN_EXP_W = 5;
  localparam int unsigned OUT_EXP_W = 6;
  localparam int unsigned RAW_COEFF_W = 32;
  localparam int unsigned MOD_W = 16;
endpackage
`default_nettype wire

// ===== sv/gpm_if.sv =====
// Valid/ready channel interfaces for term and product beats.
// Depends on gpm_pkg.
`default_nettype none
interface gpm_term_if;
  logic valid;
  logic ready;
  logic factor_select;
  logic [gpm_pkg::IN_EXP_W-1:0] exponent;
  logic signed [gpm_pkg::RAW_COEFF_W-1:0] coefficient;
  logic end_of_job;
  modport source (output valid, factor_select, exponent, coefficient, end_of_job,
                  input ready);
  modport sink (input valid, factor_select, exponent, coefficient, end_of_job,
                output ready);
  modport monitor (input valid, ready, factor_select, exponent, coefficient, end_of_job);
endinterface

interface gpm_result_if;
  logic valid;
  logic ready;
  logic [gpm_pkg::OUT_EXP_W-1:0] result_exponent;
  logic [gpm_pkg::MOD_W-1:0] result_coefficient;
  logic last_term;
  modport source (output valid, result_exponent, result_coefficient, last_term,
                  input ready);
  modport sink (input valid, result_exponent, result_coefficient, last_term,
                output ready);
  modport monitor (input valid, ready, result_exponent, result_coefficient, last_term);
endinterface
`default_nettype wire

// ===== sv/gpm_mac_cell.sv =====
// One product cell: accumulates acc + a*b mod m, then shifts its value toward output.
// Depends on gpm_pkg.
`default_nettype none
module gpm_mac_cell #(
  parameter int unsigned CW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [CW-1:0] mod_i,
  input  wire logic          step_i,
  input  wire logic          abit_i,
  input  wire logic          add_i,
  input  wire logic [CW-1:0] b_i,
  input  wire logic          shift_i,
  input  wire logic [CW-1:0] shift_in_i,
  output logic      [CW-1:0] acc_o
);
  // a*b mod m is built MSB first over the bits of a (double, then add b),
  // then folded into the accumulator on the add step
  logic [CW-1:0] t_q;
  logic [CW-1:0] t_d;
  logic [CW-1:0] acc_d;
  logic [CW-1:0] t_dbl;
  logic [CW:0]   dbl;
  logic [CW:0]   sum;
  logic [CW:0]   acc_sum;
  assign dbl     = {t_q, 1'b0};
  assign t_dbl   = (dbl >= {1'b0, mod_i}) ? CW'(dbl - {1'b0, mod_i}) : dbl[CW-1:0];
  assign sum     = {1'b0, t_dbl} + {1'b0, {CW{abit_i}} & b_i};
  assign acc_sum = {1'b0, acc_o} + {1'b0, t_q};
  always_comb begin
    t_d   = t_q;
    acc_d = acc_o;
    if (shift_i) begin
      acc_d = shift_in_i;
    end else if (add_i) begin
      acc_d = (acc_sum >= {1'b0, mod_i}) ? CW'(acc_sum - {1'b0, mod_i}) : acc_sum[CW-1:0];
      t_d   = '0;
    end else if (step_i) begin
      t_d = (sum >= {1'b0, mod_i}) ? CW'(sum - {1'b0, mod_i}) : sum[CW-1:0];
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_o <= '0;
      t_q   <= '0;
    end else begin
      acc_o <= acc_d;
      t_q   <= t_d;
    end
  end
endmodule
`default_nettype wire

// ===== sv/gpm_reduce.sv =====
// Sequential reduction of a signed 32-bit coefficient modulo m (restoring, one bit a cycle).
// Depends on gpm_pkg.
`default_nettype none
module gpm_reduce #(
  parameter int unsigned CW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   raw_i,
  input  wire logic [CW-1:0] mod_i,
  output logic               done_o,
  output logic      [CW-1:0] res_o
);
  logic [31:0]   mag_q;
  logic          neg_q;
  logic [CW:0]   rem_q;
  logic [5:0]    cnt_q;
  logic          busy_q;
  logic [CW+1:0] sh;
  assign sh = {rem_q, mag_q[31]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= raw_i[31];
      mag_q <= raw_i[31] ? (32'd0 - raw_i) : raw_i;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[30:0], 1'b0};
      rem_q <= (sh >= {2'b0, mod_i}) ? (CW+1)'(sh - {2'b0, mod_i}) : sh[CW:0];
    end
  end
  always_comb begin
    res_o = rem_q[CW-1:0];
    if (neg_q && rem_q != '0) res_o = mod_i - rem_q[CW-1:0];
  end
endmodule
`default_nettype wire

// ===== sv/gfp_polynomial_multiply.sv =====
// GF(p) polynomial multiplier. Each loaded term: after accept, a 32-step bit-serial
// reduction, a handover and a store update before the next ready. End term: the same,
// then CW bit steps and one add step per first-factor exponent in the product cell
// chain, which then shifts out one exponent per cycle up to the top nonzero one, one
// beat per nonzero term (one zero beat for a zero product); a stalled sink stalls the
// shift. Throughput: one term at a time. Reset clears all stores and sets modulus to 2.
`default_nettype none
module gfp_polynomial_multiply #(
  parameter int unsigned MAX_DEGREE  = 31,
  parameter int unsigned COEFF_WIDTH = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [gpm_pkg::MOD_W-1:0] cfg_wdata_i,
  gpm_term_if.sink                     term_i,
  gpm_result_if.source                 result_o
);
  localparam int unsigned FD = MAX_DEGREE + 1;
  localparam int unsigned PD = 2 * MAX_DEGREE + 1;
  localparam int unsigned CW = COEFF_WIDTH;
  localparam int unsigned FIW = $clog2(FD + 2);
  localparam int unsigned PIW = $clog2(PD + 1);
  localparam int unsigned BW = $clog2(CW + 1);
  localparam int unsigned BIW = $clog2(CW);

  typedef enum logic [2:0] {S_IDLE, S_RED, S_UPD, S_MAC, S_OUT} state_e;
  state_e state_q;

  logic [gpm_pkg::MOD_W-1:0] modulus_q;
  logic [CW-1:0] m;
  always_comb begin
    m = modulus_q[CW-1:0];
    if (m < CW'(2)) m = CW'(2);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) modulus_q <= 16'd2;
    else if (cfg_we_i) modulus_q <= cfg_wdata_i;
  end

  logic [CW-1:0] fa_q [FD];
  logic [CW-1:0] fb_q [FD];
  logic          sel_q, end_q, inrange_q;
  logic [gpm_pkg::IN_EXP_W-1:0] exp_q;
  logic          red_start, red_done;
  logic [CW-1:0] red_res;

  gpm_reduce #(.CW(CW)) u_red (
    .clk_i, .rst_ni, .start_i(red_start), .raw_i(term_i.coefficient),
    .mod_i(m), .done_o(red_done), .res_o(red_res)
  );

  assign term_i.ready = (state_q == S_IDLE);
  assign red_start = term_i.valid && term_i.ready;

  // chain control: per first-factor exponent, CW bit steps then one add step
  logic [FIW-1:0] i_q;
  logic [BW-1:0]  b_q;
  logic [PIW-1:0] o_q;
  logic           step_en, add_en, shift_en;
  logic [CW-1:0]  acc [PD];
  logic [CW-1:0]  a_cur;
  logic [$clog2(FD)-1:0] i_idx;
  logic [BIW-1:0] bit_idx;
  logic           a_bit;
  assign i_idx    = i_q[$clog2(FD)-1:0];
  assign a_cur    = (i_q < FIW'(FD)) ? fa_q[i_idx] : '0;
  assign bit_idx  = BIW'(CW - 1) - b_q[BIW-1:0];
  assign a_bit    = a_cur[bit_idx];
  assign step_en  = (state_q == S_MAC) && (b_q != BW'(CW));
  assign add_en   = (state_q == S_MAC) && (b_q == BW'(CW));
  assign shift_en = (state_q == S_OUT) && (!result_o.valid || result_o.ready);

  for (genvar k = 0; k < PD; k++) begin : g_cell
    logic [CW-1:0] b_sel;
    logic [CW-1:0] sin;
    always_comb begin
      b_sel = '0;
      for (int j = 0; j < FD; j++) begin
        if (int'(k) - j == int'(i_q)) b_sel = fb_q[j];
      end
    end
    if (k == PD - 1) begin : g_end
      assign sin = '0;
    end else begin : g_mid
      assign sin = acc[k+1];
    end
    gpm_mac_cell #(.CW(CW)) u_cell (
      .clk_i, .rst_ni, .mod_i(m), .step_i(step_en), .abit_i(a_bit), .add_i(add_en),
      .b_i(b_sel), .shift_i(shift_en), .shift_in_i(sin),
      .acc_o(acc[k])
    );
  end

  // any nonzero left in the chain ahead of cell 0
  logic rest_nz;
  always_comb begin
    rest_nz = 1'b0;
    for (int k = 1; k < PD; k++) rest_nz |= (acc[k] != '0);
  end
  logic emitted_q;
  logic [CW:0] upd_sum;
  logic [CW-1:0] old_v;
  assign old_v   = sel_q ? fb_q[exp_q[$clog2(FD)-1:0]] : fa_q[exp_q[$clog2(FD)-1:0]];
  assign upd_sum = {1'b0, old_v} + {1'b0, red_res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0;
      b_q <= '0;
      o_q <= '0;
      emitted_q <= 1'b0;
      sel_q <= 1'b0;
      exp_q <= '0;
      end_q <= 1'b0;
      inrange_q <= 1'b0;
      result_o.valid <= 1'b0;
      result_o.result_exponent <= '0;
      result_o.result_coefficient <= '0;
      result_o.last_term <= 1'b0;
      for (int j = 0; j < FD; j++) begin
        fa_q[j] <= '0;
        fb_q[j] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: if (red_start) begin
          sel_q <= term_i.factor_select;
          exp_q <= term_i.exponent;
          end_q <= term_i.end_of_job;
          inrange_q <= ({1'b0, term_i.exponent} <= 6'(MAX_DEGREE));
          state_q <= S_RED;
        end
        S_RED: if (red_done) state_q <= S_UPD;
        S_UPD: begin
          if (inrange_q) begin
            if (sel_q) fb_q[exp_q[$clog2(FD)-1:0]] <= (upd_sum >= {1'b0, m}) ?
                CW'(upd_sum - {1'b0, m}) : upd_sum[CW-1:0];
            else fa_q[exp_q[$clog2(FD)-1:0]] <= (upd_sum >= {1'b0, m}) ?
                CW'(upd_sum - {1'b0, m}) : upd_sum[CW-1:0];
          end
          i_q <= '0;
          b_q <= '0;
          state_q <= end_q ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (b_q == BW'(CW)) begin
            b_q <= '0;
            i_q <= i_q + FIW'(1);
            if (i_q == FIW'(FD - 1)) begin
              state_q <= S_OUT;
              o_q <= '0;
              emitted_q <= 1'b0;
              for (int j = 0; j < FD; j++) begin
                fa_q[j] <= '0;
                fb_q[j] <= '0;
              end
            end
          end else begin
            b_q <= b_q + BW'(1);
          end
        end
        S_OUT: if (shift_en) begin
          // cell 0 holds exponent o_q; chain shifts toward cell 0 each beat slot
          result_o.valid <= 1'b0;
          if (acc[0] != '0 || (!rest_nz && !emitted_q)) begin
            result_o.valid <= 1'b1;
            result_o.result_exponent <= o_q[gpm_pkg::OUT_EXP_W-1:0];
            result_o.result_coefficient <= gpm_pkg::MOD_W'(acc[0]);
            result_o.last_term <= !rest_nz;
            emitted_q <= 1'b1;
          end
          o_q <= o_q + PIW'(1);
          if (!rest_nz) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q != S_OUT && result_o.valid && result_o.ready) result_o.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== dv/gpm_checker.sv =====
// Checker for the GF(p) polynomial multiplier: watches term and product beats,
// predicts product terms and compares them. Depends on gpm_pkg and gpm_if.
`timescale 1ns / 100ps
module gpm_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  gpm_term_if.monitor            term_mon,
  gpm_result_if.monitor          res_mon,
  output int unsigned            fail_count,
  output int unsigned            pending
);
  typedef struct packed {
    logic [gpm_pkg::OUT_EXP_W-1:0] exp;
    logic [gpm_pkg::MOD_W-1:0]     coeff;
    logic                          last;
  } prod_term_t;

  prod_term_t exp_fifo[1024];
  int unsigned wr_cnt, rd_cnt;
  logic [15:0] modulus_q;
  logic [31:0] fac_a[32];
  logic [31:0] fac_b[32];

  assign pending = wr_cnt - rd_cnt;

  task automatic store_expected(prod_term_t t);
    exp_fifo[wr_cnt[9:0]] = t;
    wr_cnt++;
  endtask

  function automatic logic [31:0] reduce_coeff(logic [31:0] raw, logic [31:0] m);
    logic [32:0] mag;
    logic [31:0] r;
    if (raw[31]) begin
      mag = 33'h1_0000_0000 - {1'b0, raw};
      r = 32'(mag % m);
      return (r == 0) ? 32'd0 : m - r;
    end
    return raw % m;
  endfunction

  task automatic multiply_job(logic [31:0] m);
    logic [31:0] prod[63];
    logic [63:0] p;
    int top;
    prod_term_t t;
    top = -1;
    for (int i = 0; i < 63; i++) prod[i] = 0;
    for (int i = 0; i < 32; i++)
      for (int j = 0; j < 32; j++) begin
        p = (64'(fac_a[i]) * 64'(fac_b[j])) % m;
        prod[i+j] = 32'((64'(prod[i+j]) + p) % m);
      end
    for (int i = 0; i < 63; i++) if (prod[i] != 0) top = i;
    if (top < 0) begin
      t = '{exp: '0, coeff: '0, last: 1'b1};
      store_expected(t);
    end else begin
      for (int i = 0; i <= top; i++)
        if (prod[i] != 0) begin
          t.exp = i[5:0];
          t.coeff = prod[i][15:0];
          t.last = (i == top);
          store_expected(t);
        end
    end
    for (int i = 0; i < 32; i++) begin
      fac_a[i] = 0;
      fac_b[i] = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] m, c;
    prod_term_t got, exp_t;
    if (!rst_ni) begin
      modulus_q <= 16'd2;
      for (int i = 0; i < 32; i++) begin
        fac_a[i] = 0;
        fac_b[i] = 0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
      fail_count <= 0;
    end else begin
      if (cfg_we_i) modulus_q <= cfg_wdata_i;
      m = (modulus_q < 2) ? 32'd2 : {16'd0, modulus_q};
      if (term_mon.valid && term_mon.ready) begin
        c = reduce_coeff(term_mon.coefficient, m);
        if (term_mon.factor_select)
          fac_b[term_mon.exponent] = (fac_b[term_mon.exponent] + c) % m;
        else
          fac_a[term_mon.exponent] = (fac_a[term_mon.exponent] + c) % m;
        if (term_mon.end_of_job) multiply_job(m);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{exp: res_mon.result_exponent, coeff: res_mon.result_coefficient,
                last: res_mon.last_term};
        if (wr_cnt == rd_cnt) begin
          if (fail_count < 10) $display("unexpected product beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_t = exp_fifo[rd_cnt[9:0]];
          rd_cnt++;
          if (got !== exp_t) begin
            if (fail_count < 10) $display("mismatch: expected %p, got %p", exp_t, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for gfp_polynomial_multiply: drives term beats and modulus writes,
// paces the product sink, gives the verdict. Depends on gpm_pkg, gpm_if, gpm_checker.
`timescale 1ns / 100ps
module tb_top;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  int unsigned fail_count, pending;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;

  gpm_term_if term_ch();
  gpm_result_if res_ch();

  gfp_polynomial_multiply uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .term_i(term_ch.sink), .result_o(res_ch.source)
  );

  gpm_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .term_mon(term_ch.monitor), .res_mon(res_ch.monitor),
    .fail_count, .pending
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // product sink pacing
  always @(posedge clk_i) begin
    if (hold_off) res_ch.ready <= 1'b0;
    else res_ch.ready <= no_idle || ($urandom_range(99) >= 21);
  end

  task automatic send_term(bit sel, logic [4:0] e, logic [31:0] c, bit last);
    while (!no_idle && $urandom_range(99) < 21) @(posedge clk_i);
    term_ch.valid <= 1'b1;
    term_ch.factor_select <= sel;
    term_ch.exponent <= e;
    term_ch.coefficient <= c;
    term_ch.end_of_job <= last;
    @(posedge clk_i);
    while (!term_ch.ready) @(posedge clk_i);
    term_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_modulus(logic [15:0] m);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(20);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_job(int n);
    for (int i = 0; i < n; i++)
      send_term(1'($urandom_range(1)), 5'($urandom_range(31)), rand_coeff(), i == n - 1);
  endtask

  initial begin
    logic [15:0] mods[6] = '{16'd65521, 16'd7, 16'd0, 16'd12, 16'd3, 16'd65535};
    term_ch.valid = 1'b0;
    term_ch.factor_select = 1'b0;
    term_ch.exponent = '0;
    term_ch.coefficient = '0;
    term_ch.end_of_job = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: default modulus 2, extremes of exponents and coefficients
    send_term(1'b0, 5'd0, 32'h8000_0000, 1'b1);              // zero product
    send_term(1'b0, 5'd31, 32'h7fff_ffff, 1'b0);
    send_term(1'b1, 5'd31, 32'hffff_ffff, 1'b1);             // top exponent 62
    set_modulus(16'd65521);
    send_term(1'b0, 5'd0, 32'h8000_0000, 1'b0);
    send_term(1'b0, 5'd0, 32'h0000_0005, 1'b0);              // equal exponents add
    send_term(1'b1, 5'd0, 32'hffff_ffff, 1'b0);
    send_term(1'b1, 5'd17, 32'd65521, 1'b0);                 // reduces to zero
    send_term(1'b1, 5'd31, 32'd1234, 1'b1);
    send_term(1'b1, 5'd3, 32'd9, 1'b1);                       // empty first factor
    set_modulus(16'd1);                                       // below two
    send_term(1'b0, 5'd1, 32'd1, 1'b0);
    send_term(1'b1, 5'd2, 32'd3, 1'b1);
    // long sink hold-off while terms keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 4; k++) random_job(4);
    join
    for (int k = 0; k < 40; k++) begin
      if (k % 7 == 0) set_modulus(mods[(k / 7) % 6]);
      no_idle = (k >= 20 && k < 26);
      random_job($urandom_range(1, 8));
    end
    no_idle = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("** gfp_polynomial_multiply: PASSED **");
    else $display("** gfp_polynomial_multiply: FAILED **");
    $finish;
  end

  initial begin
    #200ms;
    $display("** gfp_polynomial_multiply: FAILED **");
    $finish;
  end
endmodule
